// File: sv/pcs_pkg.sv
// Shared types and constants for the prime classifier with statistics.
// Holds the controller state encoding and the command/status structs.
// No dependencies.
package pcs_pkg;

  localparam int CountWidth  = 32;
  localparam int SumWidth    = 64;
  localparam int MaxOutWidth = 32;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_TEST = 5'b00010,
    ST_DIV  = 5'b00100,
    ST_NEXT = 5'b01000,
    ST_FIN  = 5'b10000
  } state_e;

  typedef struct packed {
    logic load;
    logic div_start;
    logic div_step;
    logic next_div;
    logic set_flag;
    logic flag_val;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic trivial;
    logic trivial_prime;
    logic sq_over;
    logic div_last;
    logic rem_zero;
    logic out_busy;
  } sts_t;

endpackage

// File: sv/pcs_ctrl.sv
// Controller for the prime classifier: sequences load, trial, divide, finish.
// Depends on pcs_pkg (state_e, cmd_t, sts_t).
module pcs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  pcs_pkg::sts_t sts_i,
  output pcs_pkg::cmd_t cmd_o
);

  pcs_pkg::state_e state_q, state_d;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_stall_o = (state_q != pcs_pkg::ST_IDLE);
    unique case (state_q)
      pcs_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = pcs_pkg::ST_TEST;
        end
      end
      pcs_pkg::ST_TEST: begin
        if (sts_i.trivial) begin
          cmd_o.set_flag = 1'b1;
          cmd_o.flag_val = sts_i.trivial_prime;
          state_d        = pcs_pkg::ST_FIN;
        end else if (sts_i.sq_over) begin
          cmd_o.set_flag = 1'b1;
          cmd_o.flag_val = 1'b1;
          state_d        = pcs_pkg::ST_FIN;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = pcs_pkg::ST_DIV;
        end
      end
      pcs_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = pcs_pkg::ST_NEXT;
        end
      end
      pcs_pkg::ST_NEXT: begin
        if (sts_i.rem_zero) begin
          cmd_o.set_flag = 1'b1;
          cmd_o.flag_val = 1'b0;
          state_d        = pcs_pkg::ST_FIN;
        end else begin
          cmd_o.next_div = 1'b1;
          state_d        = pcs_pkg::ST_TEST;
        end
      end
      pcs_pkg::ST_FIN: begin
        if (!sts_i.out_busy) begin
          cmd_o.finish = 1'b1;
          state_d      = pcs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pcs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcs_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: sv/pcs_datapath.sv
// Datapath for the prime classifier: trial divisor, remainder unit (two
// bits a cycle), running statistics and the output register.
// Depends on pcs_pkg (cmd_t, sts_t, width constants).
module pcs_datapath #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic signed [VALUE_WIDTH-1:0]          value_i,
  input  pcs_pkg::cmd_t                          cmd_i,
  output pcs_pkg::sts_t                          sts_o,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic                                   is_prime_o,
  output logic [pcs_pkg::CountWidth-1:0]         prime_count_o,
  output logic signed [pcs_pkg::SumWidth-1:0]    prime_sum_o,
  output logic [pcs_pkg::CountWidth-1:0]         other_count_o,
  output logic signed [pcs_pkg::SumWidth-1:0]    other_sum_o,
  output logic signed [pcs_pkg::MaxOutWidth-1:0] max_value_o,
  output logic [pcs_pkg::CountWidth-1:0]         max_position_o,
  output logic [pcs_pkg::CountWidth-1:0]         item_index_o
);

  localparam int DW    = VALUE_WIDTH / 2 + 2;
  localparam int DSQW  = 2 * DW;
  localparam int STEPS = (VALUE_WIDTH + 1) / 2;
  localparam int NPW   = 2 * STEPS;
  localparam int CW    = $clog2(STEPS);
  localparam int CNTW  = pcs_pkg::CountWidth;
  localparam int SW    = pcs_pkg::SumWidth;

  localparam logic [CNTW-1:0]      CntMax = '1;
  localparam logic signed [SW-1:0] SumMax = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SumMin = {1'b1, {(SW-1){1'b0}}};

  logic signed [VALUE_WIDTH-1:0] v_q;
  logic [DW-1:0]                 d_q;
  logic [DSQW-1:0]               dsq_q;
  logic [DW-1:0]                 r_q, r_d;
  logic [NPW-1:0]                nsh_q;
  logic [CW-1:0]                 cnt_q;
  logic                          flag_q;

  logic [CNTW-1:0]               prime_cnt_q, other_cnt_q, items_q, max_pos_q;
  logic signed [SW-1:0]          prime_sum_q, other_sum_q;
  logic signed [VALUE_WIDTH-1:0] max_q;
  logic                          out_valid_q, out_prime_q;

  logic [DW:0]                   t0, t1;
  logic signed [SW-1:0]          v64, max64;
  logic [CNTW-1:0]               items_inc;

  function automatic logic [CNTW-1:0] sat_inc(input logic [CNTW-1:0] c);
    sat_inc = (c == CntMax) ? c : c + 1'b1;
  endfunction

  function automatic logic signed [SW-1:0] sat_add(input logic signed [SW-1:0] a,
                                                   input logic signed [SW-1:0] b);
    logic signed [SW-1:0] s;
    s = a + b;
    if ((a[SW-1] == b[SW-1]) && (s[SW-1] != a[SW-1])) begin
      sat_add = b[SW-1] ? SumMin : SumMax;
    end else begin
      sat_add = s;
    end
  endfunction

  // two restoring steps per cycle
  always_comb begin
    t0 = {r_q, nsh_q[NPW-1]};
    if (t0 >= {1'b0, d_q}) begin
      t0 = t0 - {1'b0, d_q};
    end
    t1 = {t0[DW-1:0], nsh_q[NPW-2]};
    if (t1 >= {1'b0, d_q}) begin
      t1 = t1 - {1'b0, d_q};
    end
    r_d = t1[DW-1:0];
  end

  assign v64       = SW'(v_q);
  assign max64     = SW'(max_q);
  assign items_inc = sat_inc(items_q);

  assign sts_o.trivial       = (v_q <= VALUE_WIDTH'(signed'(2'sd1))) || !v_q[0];
  assign sts_o.trivial_prime = (v_q == VALUE_WIDTH'(2));
  assign sts_o.sq_over       = dsq_q > DSQW'($unsigned(v_q));
  assign sts_o.div_last      = (cnt_q == CW'(STEPS - 1));
  assign sts_o.rem_zero      = (r_q == '0);
  assign sts_o.out_busy      = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      v_q   <= value_i;
      d_q   <= DW'(3);
      dsq_q <= DSQW'(9);
    end
    if (cmd_i.next_div) begin
      d_q   <= d_q + DW'(2);
      dsq_q <= dsq_q + DSQW'({d_q, 2'b00}) + DSQW'(4);
    end
    if (cmd_i.div_start) begin
      r_q   <= '0;
      cnt_q <= '0;
      nsh_q <= NPW'($unsigned(v_q));
    end
    if (cmd_i.div_step) begin
      r_q   <= r_d;
      cnt_q <= cnt_q + 1'b1;
      nsh_q <= {nsh_q[NPW-3:0], 2'b00};
    end
    if (cmd_i.set_flag) begin
      flag_q <= cmd_i.flag_val;
    end
    if (cmd_i.finish) begin
      out_prime_q <= flag_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prime_cnt_q <= '0;
      other_cnt_q <= '0;
      items_q     <= '0;
      max_pos_q   <= '0;
      prime_sum_q <= '0;
      other_sum_q <= '0;
      max_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.finish) begin
        items_q <= items_inc;
        if (flag_q) begin
          prime_cnt_q <= sat_inc(prime_cnt_q);
          prime_sum_q <= sat_add(prime_sum_q, v64);
        end else begin
          other_cnt_q <= sat_inc(other_cnt_q);
          other_sum_q <= sat_add(other_sum_q, v64);
        end
        if ((items_q == '0) || (v_q > max_q)) begin
          max_q     <= v_q;
          max_pos_q <= items_inc;
        end
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign is_prime_o     = out_prime_q;
  assign prime_count_o  = prime_cnt_q;
  assign prime_sum_o    = prime_sum_q;
  assign other_count_o  = other_cnt_q;
  assign other_sum_o    = other_sum_q;
  assign max_value_o    = max64[pcs_pkg::MaxOutWidth-1:0];
  assign max_position_o = max_pos_q;
  assign item_index_o   = items_q;

endmodule

// File: sv/prime_classifier_with_stats.sv
// Top level of the prime classifier with running statistics.
// Joins pcs_ctrl and pcs_datapath; depends on pcs_pkg.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_stall_o | value_i
//   out     | output    | out_valid_o/out_stall_i | is_prime_o and the statistics
//
// Values below 3 and even values are settled in the test step, with no division.
// Each odd trial divisor passes through the test, divide and next steps in the
// shared remainder unit (two bits a cycle); a 32-bit prime near 2^31 takes about
// 23170 trials.
// Reset clears all statistics at once. A new beat is taken while a result
// waits; a stalled result holds the block in its final step.
module prime_classifier_with_stats #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [VALUE_WIDTH-1:0]          value_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic                                   is_prime_o,
  output logic [pcs_pkg::CountWidth-1:0]         prime_count_o,
  output logic signed [pcs_pkg::SumWidth-1:0]    prime_sum_o,
  output logic [pcs_pkg::CountWidth-1:0]         other_count_o,
  output logic signed [pcs_pkg::SumWidth-1:0]    other_sum_o,
  output logic signed [pcs_pkg::MaxOutWidth-1:0] max_value_o,
  output logic [pcs_pkg::CountWidth-1:0]         max_position_o,
  output logic [pcs_pkg::CountWidth-1:0]         item_index_o
);

  pcs_pkg::cmd_t cmd;
  pcs_pkg::sts_t sts;

  pcs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pcs_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .value_i        (value_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .is_prime_o     (is_prime_o),
    .prime_count_o  (prime_count_o),
    .prime_sum_o    (prime_sum_o),
    .other_count_o  (other_count_o),
    .other_sum_o    (other_sum_o),
    .max_value_o    (max_value_o),
    .max_position_o (max_position_o),
    .item_index_o   (item_index_o)
  );

endmodule
